[rtl/core/pglc_pkg.sv]
// ----------------------------------------------------------------------------
// pglc_pkg: shared types and constants for the pinch gesture level control
// Gesture mode codes, level limits, config indexes, result layout and the
// command/status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package pglc_pkg;

  // gesture mode codes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_REL_BRT  = 3'd1;
  localparam logic [2:0] MODE_ADJ_BRT  = 3'd2;
  localparam logic [2:0] MODE_REL_COL  = 3'd3;
  localparam logic [2:0] MODE_ADJ_COL  = 3'd4;
  localparam logic [2:0] MODE_END_REL  = 3'd5;

  localparam logic [3:0] LEVEL_MAX     = 4'd10;
  localparam logic [3:0] BRT_RESET     = 4'd5;
  localparam logic [3:0] COL_RESET     = 4'd0;

  // config register indexes
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MARGIN    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP      = 2'd3;

  localparam int unsigned THR_W        = 12;
  localparam int unsigned WIDTH_W      = 13;
  localparam int unsigned MARGIN_W     = 12;
  localparam int unsigned STEP_W       = 12;

  localparam logic [THR_W-1:0]    THR_RESET    = 12'd30;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd40;
  localparam logic [STEP_W-1:0]   STEP_RESET   = 12'd40;

  // result beat: brightness[3:0], color[7:4], mode[10:8], pinch[11], pad
  localparam int unsigned OUT_W        = 16;
  localparam int unsigned OUT_PAD      = 4;

  typedef struct packed {
    logic load_in;   // capture coordinates
    logic sq_x;      // acc = dx*dx
    logic sq_y;      // acc += dy*dy
    logic cmp;       // pinch = acc < thr*thr
    logic decide;    // mode update, divider init
    logic div_step;  // one subtract step / level writeback
    logic load_out;  // move result into output register
  } pglc_cmd_t;

  typedef struct packed {
    logic need_level;
    logic div_done;
    logic out_free;
  } pglc_status_t;

endpackage

[rtl/core/pglc_ctrl.sv]
// ----------------------------------------------------------------------------
// pglc_ctrl: frame sequencer
// Walks each accepted frame through square, compare, decide, divide (when
// a level update is needed) and output steps of the datapath.
// ----------------------------------------------------------------------------
module pglc_ctrl import pglc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_fire,
  output logic         in_ready,
  input  pglc_status_t sts,
  output pglc_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQX    = 3'd1;
  localparam logic [2:0] S_SQY    = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load_in = in_fire;
        if (in_fire) state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.need_level ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/pglc_dp.sv]
// ----------------------------------------------------------------------------
// pglc_dp: datapath
// Config registers, shared squarer, pinch compare, gesture mode register,
// repeated-subtraction level divider and the output register.
// ----------------------------------------------------------------------------
module pglc_dp import pglc_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // frame coordinates
  input  logic [COORD_BITS-1:0] thumb_x,
  input  logic [COORD_BITS-1:0] thumb_y,
  input  logic [COORD_BITS-1:0] index_x,
  input  logic [COORD_BITS-1:0] index_y,
  // sequencer
  input  pglc_cmd_t             cmd,
  output pglc_status_t          sts,
  // result
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      out_data
);

  localparam int MUL_W = (COORD_BITS > THR_W) ? COORD_BITS : THR_W;
  localparam int ACC_W = 2 * MUL_W + 1;
  localparam int REM_W = (COORD_BITS > MARGIN_W) ? COORD_BITS : MARGIN_W;

  logic [THR_W-1:0]      thr_r;
  logic [WIDTH_W-1:0]    width_r;
  logic [MARGIN_W-1:0]   margin_r;
  logic [STEP_W-1:0]     step_r;

  logic [COORD_BITS-1:0] tx_r, ty_r, ix_r, iy_r;
  logic [ACC_W-1:0]      acc_r;
  logic                  pinch_r;
  logic [2:0]            mode_r, mode_nxt;
  logic [3:0]            bright_r, color_r;
  logic                  tgt_col_r;
  logic [REM_W-1:0]      rem_r;
  logic [3:0]            q_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic [COORD_BITS-1:0] dx, dy;
  logic [MUL_W-1:0]      mul_op;
  logic [2*MUL_W-1:0]    mul_p;
  logic [MUL_W-1:0]      half_w;
  logic [REM_W-1:0]      step_eff;
  logic [REM_W-1:0]      rem_init;
  logic [3:0]            level;
  logic                  adjusting;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      width_r  <= WIDTH_RESET;
      margin_r <= MARGIN_RESET;
      step_r   <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
        CFG_WIDTH:     width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_MARGIN:    margin_r <= cfg_data[MARGIN_W-1:0];
        CFG_STEP:      step_r   <= cfg_data[STEP_W-1:0];
        default:       ;
      endcase
    end
  end

  // shared squarer
  assign dx = (tx_r >= ix_r) ? (tx_r - ix_r) : (ix_r - tx_r);
  assign dy = (ty_r >= iy_r) ? (ty_r - iy_r) : (iy_r - ty_r);

  always_comb begin
    if (cmd.sq_x)      mul_op = MUL_W'(dx);
    else if (cmd.sq_y) mul_op = MUL_W'(dy);
    else               mul_op = MUL_W'(thr_r);
  end

  assign mul_p = mul_op * mul_op;

  // mode transition
  assign half_w    = MUL_W'(width_r[WIDTH_W-1:1]);
  assign adjusting = (mode_r == MODE_ADJ_BRT) || (mode_r == MODE_ADJ_COL);

  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      MODE_IDLE: begin
        if (pinch_r) mode_nxt = (MUL_W'(tx_r) < half_w) ? MODE_REL_BRT : MODE_REL_COL;
      end
      MODE_REL_BRT: if (!pinch_r) mode_nxt = MODE_ADJ_BRT;
      MODE_REL_COL: if (!pinch_r) mode_nxt = MODE_ADJ_COL;
      MODE_ADJ_BRT: if (pinch_r)  mode_nxt = MODE_END_REL;
      MODE_ADJ_COL: if (pinch_r)  mode_nxt = MODE_END_REL;
      MODE_END_REL: if (!pinch_r) mode_nxt = MODE_IDLE;
      default:      mode_nxt = MODE_IDLE;
    endcase
  end

  // level divider: one subtract per cycle, quotient saturates at the level span
  assign step_eff = (step_r == '0) ? REM_W'(1) : REM_W'(step_r);
  assign rem_init = (REM_W'(iy_r) > REM_W'(margin_r)) ?
                    (REM_W'(iy_r) - REM_W'(margin_r)) : '0;
  assign level    = LEVEL_MAX - q_r;

  assign sts.need_level = adjusting && !pinch_r;
  assign sts.div_done   = (rem_r < step_eff) || (q_r == LEVEL_MAX);
  assign sts.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tx_r <= thumb_x;
      ty_r <= thumb_y;
      ix_r <= index_x;
      iy_r <= index_y;
    end
    if (cmd.sq_x) acc_r <= ACC_W'(mul_p);
    if (cmd.sq_y) acc_r <= acc_r + ACC_W'(mul_p);
    if (cmd.cmp)  pinch_r <= (acc_r < ACC_W'(mul_p));
    if (cmd.decide) begin
      rem_r     <= rem_init;
      q_r       <= '0;
      tgt_col_r <= (mode_r == MODE_ADJ_COL);
    end else if (cmd.div_step && !sts.div_done) begin
      rem_r <= rem_r - step_eff;
      q_r   <= q_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      bright_r <= BRT_RESET;
      color_r  <= COL_RESET;
    end else begin
      if (cmd.decide) mode_r <= mode_nxt;
      if (cmd.div_step && sts.div_done) begin
        if (tgt_col_r) color_r  <= level;
        else           bright_r <= level;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data_r <= {{OUT_PAD{1'b0}}, pinch_r, mode_r, color_r, bright_r};
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/pinch_gesture_level_control_unit.sv]
// ----------------------------------------------------------------------------
// pinch_gesture_level_control_unit: pinch gesture level control, top level
// Detects thumb/index pinches per frame and steps a six-mode gesture machine
// that selects and sets a brightness or color level (0..10).
// ----------------------------------------------------------------------------
//
//  channel | dir  | beat contents (low bits first)
//  --------+------+----------------------------------------------------------
//  in_     | in   | thumb_x, thumb_y, index_x, index_y (COORD_BITS each)
//  out_    | out  | brightness_level[3:0], color_level[3:0],
//          |      | gesture_mode[2:0], pinch_seen, 4 zero bits
//  cfg_    | in   | cfg_addr selects register, cfg_data carries its value
//
//  Frames: one at a time; divide steps run only when a level update is
//  needed, one subtract per unit of quotient in the repeated-subtraction
//  divider, at most 11 steps. The squarer serves dx, dy and thr in turn.
//  Reset: rst_n low for one clock clears mode, levels (brightness 5,
//  color 0) and config to defaults. cfg_ready is always high.
//  Stalls: a result waits in the output register while out_tready is low;
//  the next frame is still accepted and held at its output step.
//
module pinch_gesture_level_control_unit import pglc_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // frame input, low bits first: thumb_x, thumb_y, index_x, index_y, pad
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // result, low bits first: brightness_level, color_level, gesture_mode,
  // pinch_seen, pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_W-1:0]                 out_tdata,
  // config writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_ADDR_W-1:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0]            cfg_data
);

  pglc_cmd_t    cmd;
  pglc_status_t sts;
  logic         in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;

  pglc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pglc_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .thumb_x   (in_tdata[COORD_BITS-1:0]),
    .thumb_y   (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .index_x   (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .index_y   (in_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

[rtl/core/pglc_checker.sv]
// ----------------------------------------------------------------------------
// pglc_checker: port-level checks for the pinch gesture level control
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module pglc_checker import pglc_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [OUT_W-1:0]                  out_tdata
);

  // one frame in flight: no beat taken right after one is taken
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a frame is in flight");

  // waiting frame beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("waiting frame changed");

  // levels stay within the scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= LEVEL_MAX) && (out_tdata[7:4] <= LEVEL_MAX))
    else $error("level out of range");

  // a frame never reports a mode outside the six defined ones
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:8] <= MODE_END_REL))
    else $error("undefined gesture mode reported");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind pinch_gesture_level_control_unit pglc_checker #(
  .COORD_BITS (COORD_BITS)
) u_pglc_checker (.*);
